// ===== sv/laep_pkg.sv =====
// shared types, register indexes and constants of the load-adaptive eviction planner
package laep_pkg;

    localparam int BYTE_BITS_DEF   = 40;
    localparam int DECAY_DEPTH_DEF = 256;

    localparam int ACC_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int KEY_W   = 32;
    localparam int MS_W    = 32;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // input item modes
    localparam logic [1:0] MODE_COMMIT = 2'd0;
    localparam logic [1:0] MODE_PASS   = 2'd1;
    localparam logic [1:0] MODE_CAND   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_VICTIM = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_WM_LOW   = 3'd0;
    localparam logic [2:0] REG_WM_HIGH  = 3'd1;
    localparam logic [2:0] REG_LIMIT_WM = 3'd2;
    localparam logic [2:0] REG_GAIN     = 3'd3;
    localparam logic [2:0] REG_WINDOW   = 3'd4;

    localparam logic [15:0] WM_LOW_RST   = 16'd45875;
    localparam logic [15:0] WM_HIGH_RST  = 16'd58982;
    localparam logic [15:0] LIMIT_WM_RST = 16'd62259;
    localparam logic [15:0] GAIN_RST     = 16'd256;
    localparam logic [31:0] WINDOW_RST   = 32'd1000;

    typedef struct packed {
        logic [15:0] wm_low;
        logic [15:0] wm_high;
        logic [15:0] limit_wm;
        logic [15:0] rate_gain;
        logic [31:0] load_window_ms;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_COMMIT,
        OP_PASS_INIT,
        OP_SINCE,
        OP_MUL_IDX,
        OP_DIV_IDX,
        OP_DECAY,
        OP_MUL_DECAY,
        OP_ACCUM,
        OP_DIV_LOAD,
        OP_LOAD_SET,
        OP_MUL_MARK,
        OP_MARK,
        OP_DIV_U,
        OP_SET_U,
        OP_MUL_FLOOR,
        OP_FLOOR,
        OP_MUL_RATE,
        OP_DIV_RATE,
        OP_SET_RATE,
        OP_MUL_TGT,
        OP_TGT_PROD,
        OP_TGT_ZERO,
        OP_EMIT_REPORT,
        OP_EMIT_END,
        OP_CAND,
        OP_EMIT_VICTIM
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   take_in;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       cap_zero;
        logic       minr_zero;
        logic       load_valid;
        logic       win_el_ok;
        logic       ge_cap;
        logic       hi_le_lo;
        logic       u_gt_mark;
        logic       rate_ok;
        logic       used_gt_floor;
        logic       tgt_zero;
        logic       pass_active;
        logic       bytes_zero;
        logic       cand_done;
        logic       out_free;
        logic       unit_busy;
    } dp_status_t;

endpackage

// ===== sv/laep_ctrl.sv =====
// sequencing state machine of the eviction planner
module laep_ctrl import laep_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [26:0] {
        S_IDLE      = 27'd1 << 0,
        S_DECODE    = 27'd1 << 1,
        S_SINCE     = 27'd1 << 2,
        S_MUL_IDX   = 27'd1 << 3,
        S_DIV_IDX   = 27'd1 << 4,
        S_DECAY     = 27'd1 << 5,
        S_MUL_DECAY = 27'd1 << 6,
        S_ACCUM     = 27'd1 << 7,
        S_LOADCHK   = 27'd1 << 8,
        S_LOAD_SET  = 27'd1 << 9,
        S_MUL_MARK  = 27'd1 << 10,
        S_MARK      = 27'd1 << 11,
        S_DIV_U     = 27'd1 << 12,
        S_SET_U     = 27'd1 << 13,
        S_CMP       = 27'd1 << 14,
        S_MUL_FLOOR = 27'd1 << 15,
        S_FLOOR     = 27'd1 << 16,
        S_MUL_RATE  = 27'd1 << 17,
        S_DIV_RATE  = 27'd1 << 18,
        S_SET_RATE  = 27'd1 << 19,
        S_CHK_OVER  = 27'd1 << 20,
        S_TGT       = 27'd1 << 21,
        S_TGT0      = 27'd1 << 22,
        S_REPORT    = 27'd1 << 23,
        S_END       = 27'd1 << 24,
        S_CAND      = 27'd1 << 25,
        S_WAIT      = 27'd1 << 26
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cmd.op      = OP_NONE;
        cmd.take_in = 1'b0;
        case (state_reg)
            S_IDLE: begin
                cmd.take_in = s_tvalid;
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                case (st.mode)
                    MODE_COMMIT: begin
                        cmd.op     = OP_COMMIT;
                        state_next = S_IDLE;
                    end
                    MODE_PASS: begin
                        cmd.op = OP_PASS_INIT;
                        if (st.cap_zero) state_next = S_END;
                        else if (st.minr_zero) state_next = S_SINCE;
                        else state_next = S_DIV_U;
                    end
                    MODE_CAND: begin
                        if (st.pass_active) begin
                            cmd.op     = OP_CAND;
                            state_next = S_CAND;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SINCE: begin
                cmd.op = OP_SINCE;
                if (!st.load_valid) state_next = S_LOADCHK;
                else if (st.win_el_ok) state_next = S_MUL_IDX;
                else state_next = S_DECAY;
            end
            S_MUL_IDX: begin
                cmd.op = OP_MUL_IDX; ret_next = S_DIV_IDX; state_next = S_WAIT;
            end
            S_DIV_IDX: begin
                cmd.op = OP_DIV_IDX; ret_next = S_DECAY; state_next = S_WAIT;
            end
            S_DECAY: begin
                cmd.op = OP_DECAY; state_next = S_MUL_DECAY;
            end
            S_MUL_DECAY: begin
                cmd.op = OP_MUL_DECAY; ret_next = S_ACCUM; state_next = S_WAIT;
            end
            S_ACCUM: begin
                cmd.op = OP_ACCUM; state_next = S_LOADCHK;
            end
            S_LOADCHK: begin
                if (st.ge_cap) begin
                    state_next = S_LOAD_SET;
                end else begin
                    cmd.op = OP_DIV_LOAD; ret_next = S_LOAD_SET; state_next = S_WAIT;
                end
            end
            S_LOAD_SET: begin
                cmd.op = OP_LOAD_SET; state_next = S_MUL_MARK;
            end
            S_MUL_MARK: begin
                if (st.hi_le_lo) begin
                    state_next = S_MARK;
                end else begin
                    cmd.op = OP_MUL_MARK; ret_next = S_MARK; state_next = S_WAIT;
                end
            end
            S_MARK: begin
                cmd.op = OP_MARK; state_next = S_DIV_U;
            end
            S_DIV_U: begin
                cmd.op = OP_DIV_U; ret_next = S_SET_U; state_next = S_WAIT;
            end
            S_SET_U: begin
                cmd.op = OP_SET_U; state_next = S_CMP;
            end
            S_CMP: begin
                state_next = st.u_gt_mark ? S_MUL_FLOOR : S_TGT0;
            end
            S_MUL_FLOOR: begin
                cmd.op = OP_MUL_FLOOR; ret_next = S_FLOOR; state_next = S_WAIT;
            end
            S_FLOOR: begin
                cmd.op     = OP_FLOOR;
                state_next = st.rate_ok ? S_MUL_RATE : S_CHK_OVER;
            end
            S_MUL_RATE: begin
                cmd.op = OP_MUL_RATE; ret_next = S_DIV_RATE; state_next = S_WAIT;
            end
            S_DIV_RATE: begin
                cmd.op = OP_DIV_RATE; ret_next = S_SET_RATE; state_next = S_WAIT;
            end
            S_SET_RATE: begin
                cmd.op = OP_SET_RATE; state_next = S_CHK_OVER;
            end
            S_CHK_OVER: begin
                if (st.used_gt_floor) begin
                    cmd.op = OP_MUL_TGT; ret_next = S_TGT; state_next = S_WAIT;
                end else begin
                    state_next = S_TGT0;
                end
            end
            S_TGT: begin
                cmd.op = OP_TGT_PROD; state_next = S_REPORT;
            end
            S_TGT0: begin
                cmd.op = OP_TGT_ZERO; state_next = S_REPORT;
            end
            S_REPORT: begin
                if (st.out_free) begin
                    cmd.op     = OP_EMIT_REPORT;
                    state_next = st.tgt_zero ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (st.out_free) begin
                    cmd.op     = OP_EMIT_END;
                    state_next = S_IDLE;
                end
            end
            S_CAND: begin
                if (st.bytes_zero) begin
                    state_next = st.cand_done ? S_END : S_IDLE;
                end else if (st.out_free) begin
                    cmd.op     = OP_EMIT_VICTIM;
                    state_next = st.cand_done ? S_END : S_IDLE;
                end
            end
            S_WAIT: begin
                if (!st.unit_busy) state_next = ret_reg;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== sv/laep_dp.sv =====
// planner datapath: state registers, serial multiplier, serial divider, result register
module laep_dp import laep_pkg::*; #(
    parameter int BYTE_BITS         = BYTE_BITS_DEF,
    parameter int DECAY_TABLE_DEPTH = DECAY_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  dp_cmd_t              cmd,
    output dp_status_t           st,
    input  logic [1:0]           in_mode,
    input  logic                 in_commit,
    input  logic [BYTE_BITS-1:0] in_bytes,
    input  logic [BYTE_BITS-1:0] in_used,
    input  logic [BYTE_BITS-1:0] in_cap,
    input  logic [BYTE_BITS-1:0] in_minr,
    input  logic [MS_W-1:0]      in_elapsed,
    input  logic [KEY_W-1:0]     in_key,
    input  logic                 in_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [KEY_W-1:0]     m_key,
    output logic [BYTE_BITS-1:0] m_bytes,
    output logic [BYTE_BITS-1:0] m_target,
    output logic [FRAC_W-1:0]    m_wm,
    output logic                 m_sf,
    output logic                 m_last
);

    localparam int BB    = BYTE_BITS;
    localparam int WW    = (BB > ACC_W) ? BB : ACC_W;
    localparam int MX    = WW;
    localparam int PW    = MX + 17;
    localparam int DIV_W = (BB + 16 > 48) ? BB + 16 : 48;
    localparam int DVS_W = (BB > 36) ? BB : 36;
    localparam int DCW   = $clog2(DIV_W + 1);
    localparam int IW    = $clog2(DECAY_TABLE_DEPTH);

    // Q2.30 exponent of one table step
    localparam longint unsigned DECAY_STEP = (64'd16 << 30) / DECAY_TABLE_DEPTH;

    typedef logic [16:0] dtab_t [DECAY_TABLE_DEPTH];

    // shift-subtract quotient, used only while the table is built
    function automatic longint unsigned const_div(longint unsigned n, longint unsigned d);
        longint unsigned q, r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-16*i/depth) in Q1.16 from a truncated Taylor step and repeated Q2.30 products
    function automatic dtab_t build_decay();
        longint unsigned s, term, cur, b;
        longint          sum;
        dtab_t           t;
        s    = DECAY_STEP;
        sum  = 64'sd1 << 30;
        term = 64'd1 << 30;
        cur  = 64'd1 << 30;
        for (int k = 1; k <= 24; k++) begin
            term = const_div((term * s) >> 30, 64'(k));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        b = longint'(sum);
        for (int i = 0; i < DECAY_TABLE_DEPTH; i++) begin
            t[i] = 17'((cur + (64'd1 << 13)) >> 14);
            cur  = (cur * b + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction

    localparam dtab_t DECAY_TAB = build_decay();

    // latched input item
    logic [1:0]       mode_reg;
    logic             commit_reg, last_reg;
    logic [BB-1:0]    bytes_reg, used_reg, cap_reg, minr_reg;
    logic [MS_W-1:0]  elapsed_reg;
    logic [KEY_W-1:0] key_reg;

    // planner state
    logic [ACC_W-1:0]  fcb_reg, acc_reg, since_reg;
    logic              lvalid_reg, pact_reg, cdone_reg;
    logic [FRAC_W-1:0] mark_reg;
    logic [BB-1:0]     tgt_reg, plan_reg, pmin_reg, floor_reg;
    logic [16:0]       d_reg, load_reg, rate_reg;
    logic [25:0]       u_reg;

    // serial multiplier
    logic [MX-1:0] mx_reg, mx_in;
    logic [16:0]   mf_reg, mf_in;
    logic [PW-1:0] prod_reg;
    logic [4:0]    mcnt_reg;
    logic          mbusy_reg, mul_start;

    // serial divider, quotient shifts into the dividend register
    logic [DIV_W-1:0] dn_reg, dn_in;
    logic [DVS_W-1:0] dd_reg, dd_in, rem_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic             dbusy_reg, div_start;
    logic [DVS_W:0]   rem_sh;
    logic             qbit;

    // result register
    logic              ovalid_reg, olast_reg, osf_reg;
    logic [1:0]        okind_reg;
    logic [KEY_W-1:0]  okey_reg;
    logic [BB-1:0]     obytes_reg, otgt_reg;
    logic [FRAC_W-1:0] owm_reg;

    logic [WW-1:0]    la_w, cap_w, bytes_w;
    logic [ACC_W-1:0] bclamp, pm_sat;
    logic [ACC_W:0]   csum, asum;
    logic [PW-17:0]   pm;
    logic [BB:0]      psum;
    logic [BB-1:0]    plan_new, tprod;
    logic [25:0]      diff_u, dmin;
    logic             idx_ok, out_free;
    logic [16:0]      d_sel;

    assign la_w    = WW'(acc_reg);
    assign cap_w   = WW'(cap_reg);
    assign bytes_w = WW'(bytes_reg);
    assign out_free = !ovalid_reg || m_ready;

    assign bclamp = (bytes_w > WW'(ACC_MAX)) ? ACC_MAX : bytes_w[ACC_W-1:0];
    assign csum   = {1'b0, fcb_reg} + {1'b0, bclamp};
    assign pm     = prod_reg[PW-1:16];
    assign pm_sat = (pm > (PW-16)'(ACC_MAX)) ? ACC_MAX : pm[ACC_W-1:0];
    assign asum   = {1'b0, pm_sat} + {1'b0, since_reg};
    assign psum   = {1'b0, plan_reg} + {1'b0, bytes_reg};
    assign plan_new = psum[BB] ? '1 : psum[BB-1:0];
    assign tprod  = prod_reg[BB+15:16];
    assign diff_u = u_reg - 26'(cfg.wm_low);
    assign dmin   = (diff_u > 26'(1 << 24)) ? 26'(1 << 24) : diff_u;
    assign idx_ok = dn_reg < DIV_W'(DECAY_TABLE_DEPTH);
    assign d_sel  = (st.win_el_ok && idx_ok) ? DECAY_TAB[dn_reg[IW-1:0]] : 17'd0;

    assign rem_sh = {rem_reg, dn_reg[DIV_W-1]};
    assign qbit   = rem_sh >= {1'b0, dd_reg};

    always_comb begin
        st.mode          = mode_reg;
        st.cap_zero      = (cap_reg == '0);
        st.minr_zero     = (minr_reg == '0);
        st.load_valid    = lvalid_reg;
        st.win_el_ok     = (cfg.load_window_ms != '0) && (elapsed_reg != '0);
        st.ge_cap        = la_w >= cap_w;
        st.hi_le_lo      = cfg.wm_high <= cfg.wm_low;
        st.u_gt_mark     = u_reg > 26'(mark_reg);
        st.rate_ok       = (cfg.limit_wm > cfg.wm_low) && (u_reg > 26'(cfg.wm_low));
        st.used_gt_floor = used_reg > floor_reg;
        st.tgt_zero      = (tgt_reg == '0);
        st.pass_active   = pact_reg;
        st.bytes_zero    = (bytes_reg == '0);
        st.cand_done     = cdone_reg;
        st.out_free      = out_free;
        st.unit_busy     = mbusy_reg || dbusy_reg;
    end

    // operand selection for the shared units
    always_comb begin
        mul_start = 1'b1;
        mx_in     = '0;
        mf_in     = '0;
        case (cmd.op)
            OP_MUL_IDX: begin
                mx_in = MX'(elapsed_reg); mf_in = 17'(DECAY_TABLE_DEPTH);
            end
            OP_MUL_DECAY: begin
                mx_in = MX'(acc_reg); mf_in = d_reg;
            end
            OP_MUL_MARK: begin
                mx_in = MX'(cfg.wm_high - cfg.wm_low); mf_in = load_reg;
            end
            OP_MUL_FLOOR: begin
                mx_in = MX'(cap_reg); mf_in = {1'b0, cfg.wm_low};
            end
            OP_MUL_RATE: begin
                mx_in = MX'(dmin); mf_in = {1'b0, cfg.rate_gain};
            end
            OP_MUL_TGT: begin
                mx_in = MX'(used_reg - floor_reg); mf_in = rate_reg;
            end
            default: mul_start = 1'b0;
        endcase
    end

    always_comb begin
        div_start = 1'b1;
        dn_in     = '0;
        dd_in     = '0;
        case (cmd.op)
            OP_DIV_IDX: begin
                dn_in = DIV_W'(prod_reg[43:0]);
                dd_in = DVS_W'({cfg.load_window_ms, 4'b0});
            end
            OP_DIV_LOAD: begin
                dn_in = DIV_W'({la_w[BB-1:0], 16'b0});
                dd_in = DVS_W'(cap_reg);
            end
            OP_DIV_U: begin
                dn_in = DIV_W'({used_reg, 16'b0});
                dd_in = DVS_W'(cap_reg);
            end
            OP_DIV_RATE: begin
                dn_in = DIV_W'({prod_reg[40:0], 8'b0});
                dd_in = DVS_W'(cfg.limit_wm - cfg.wm_low);
            end
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            mode_reg    <= in_mode;
            commit_reg  <= in_commit;
            bytes_reg   <= in_bytes;
            used_reg    <= in_used;
            cap_reg     <= in_cap;
            minr_reg    <= in_minr;
            elapsed_reg <= in_elapsed;
            key_reg     <= in_key;
            last_reg    <= in_last;
        end
    end

    // multiplier, msb of the factor first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else if (mul_start) begin
            mbusy_reg <= 1'b1;
            mcnt_reg  <= 5'd17;
            mx_reg    <= mx_in;
            mf_reg    <= mf_in;
            prod_reg  <= '0;
        end else if (mbusy_reg) begin
            prod_reg  <= (prod_reg << 1) + (mf_reg[16] ? PW'(mx_reg) : PW'(0));
            mf_reg    <= mf_reg << 1;
            mcnt_reg  <= mcnt_reg - 5'd1;
            if (mcnt_reg == 5'd1) mbusy_reg <= 1'b0;
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (div_start) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= DCW'(DIV_W);
            dn_reg    <= dn_in;
            dd_reg    <= dd_in;
            rem_reg   <= '0;
        end else if (dbusy_reg) begin
            rem_reg  <= qbit ? DVS_W'(rem_sh - {1'b0, dd_reg}) : rem_sh[DVS_W-1:0];
            dn_reg   <= {dn_reg[DIV_W-2:0], qbit};
            dcnt_reg <= dcnt_reg - DCW'(1);
            if (dcnt_reg == DCW'(1)) dbusy_reg <= 1'b0;
        end
    end

    // planner state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcb_reg    <= '0;
            acc_reg    <= '0;
            lvalid_reg <= 1'b0;
            mark_reg   <= WM_LOW_RST;
            tgt_reg    <= '0;
            plan_reg   <= '0;
            pmin_reg   <= '0;
            pact_reg   <= 1'b0;
            cdone_reg  <= 1'b0;
        end else begin
            case (cmd.op)
                OP_COMMIT: begin
                    if (commit_reg) fcb_reg <= csum[ACC_W] ? ACC_MAX : csum[ACC_W-1:0];
                end
                OP_PASS_INIT: begin
                    pact_reg <= 1'b0;
                    plan_reg <= '0;
                    pmin_reg <= minr_reg;
                    if (cap_reg == '0) tgt_reg <= '0;
                end
                OP_SINCE: begin
                    since_reg  <= fcb_reg;
                    fcb_reg    <= '0;
                    if (!lvalid_reg) acc_reg <= fcb_reg;
                    lvalid_reg <= 1'b1;
                end
                OP_DECAY:    d_reg    <= d_sel;
                OP_ACCUM:    acc_reg  <= asum[ACC_W] ? ACC_MAX : asum[ACC_W-1:0];
                OP_LOAD_SET: load_reg <= st.ge_cap ? 17'h10000 : dn_reg[16:0];
                OP_MARK: begin
                    if (st.hi_le_lo) mark_reg <= cfg.wm_high;
                    else mark_reg <= cfg.wm_high - prod_reg[31:16];
                end
                OP_SET_U: u_reg <= (dn_reg > DIV_W'(1 << 25)) ? 26'(1 << 25) : dn_reg[25:0];
                OP_FLOOR: begin
                    floor_reg <= prod_reg[BB+15:16];
                    rate_reg  <= '0;
                end
                OP_SET_RATE: rate_reg <= (dn_reg > DIV_W'(65536)) ? 17'h10000 : dn_reg[16:0];
                OP_TGT_PROD: tgt_reg  <= (tprod < minr_reg) ? minr_reg : tprod;
                OP_TGT_ZERO: tgt_reg  <= minr_reg;
                OP_EMIT_REPORT: pact_reg <= (tgt_reg != '0);
                OP_EMIT_END:    pact_reg <= 1'b0;
                OP_CAND: begin
                    if (bytes_reg != '0) plan_reg <= plan_new;
                    cdone_reg <= last_reg || ((bytes_reg != '0) && (plan_new >= tgt_reg));
                end
                default: ;
            endcase
        end
    end

    // result register, one transfer waiting at most
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT_REPORT || cmd.op == OP_EMIT_END
                     || cmd.op == OP_EMIT_VICTIM) begin
            ovalid_reg <= 1'b1;
        end else if (m_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_EMIT_REPORT: begin
                okind_reg  <= KIND_REPORT;
                okey_reg   <= '0;
                obytes_reg <= '0;
                otgt_reg   <= tgt_reg;
                owm_reg    <= mark_reg;
                osf_reg    <= 1'b0;
                olast_reg  <= (tgt_reg != '0);
            end
            OP_EMIT_END: begin
                okind_reg  <= KIND_END;
                okey_reg   <= '0;
                obytes_reg <= plan_reg;
                otgt_reg   <= tgt_reg;
                owm_reg    <= mark_reg;
                osf_reg    <= (pmin_reg != '0) && (plan_reg < pmin_reg);
                olast_reg  <= 1'b1;
            end
            OP_EMIT_VICTIM: begin
                okind_reg  <= KIND_VICTIM;
                okey_reg   <= key_reg;
                obytes_reg <= bytes_reg;
                otgt_reg   <= tgt_reg;
                owm_reg    <= mark_reg;
                osf_reg    <= 1'b0;
                olast_reg  <= !cdone_reg;
            end
            default: ;
        endcase
    end

    assign m_valid  = ovalid_reg;
    assign m_kind   = okind_reg;
    assign m_key    = okey_reg;
    assign m_bytes  = obytes_reg;
    assign m_target = otgt_reg;
    assign m_wm     = owm_reg;
    assign m_sf     = osf_reg;
    assign m_last   = olast_reg;

endmodule

// ===== sv/load_adaptive_eviction_planner.sv =====
// Eviction planner for a fast cache tier: a pass start runs on a restoring divider of DIV_W =
// max(BYTE_BITS+16, 48) steps and a 17-step shift-add multiplier, plus any wait on the output
// register; results leave through a one-entry output register, so the block takes the next item
// while a result waits.
module load_adaptive_eviction_planner import laep_pkg::*; #(
    parameter int BYTE_BITS         = BYTE_BITS_DEF,
    parameter int DECAY_TABLE_DEPTH = DECAY_DEPTH_DEF,
    localparam int IN_W  = 65 + 4 * BYTE_BITS,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 49 + 2 * BYTE_BITS,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // commit_to_fast, byte_count, used_bytes, capacity_bytes, min_reclaim,
    // elapsed_ms, victim_key
    input  logic [IN_TW-1:0]  s_tdata,
    input  logic [1:0]        s_tuser,   // mode
    input  logic              s_tlast,   // last_candidate
    output logic              m_tvalid,
    input  logic              m_tready,
    // out_key, out_bytes, target_bytes, watermark, shortfall
    output logic [OUT_TW-1:0] m_tdata,
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast,   // last
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int BB = BYTE_BITS;

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t st;

    logic [KEY_W-1:0]  m_key;
    logic [BB-1:0]     m_bytes, m_target;
    logic [FRAC_W-1:0] m_wm;
    logic              m_sf;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wm_low         <= WM_LOW_RST;
            cfg_reg.wm_high        <= WM_HIGH_RST;
            cfg_reg.limit_wm       <= LIMIT_WM_RST;
            cfg_reg.rate_gain      <= GAIN_RST;
            cfg_reg.load_window_ms <= WINDOW_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_WM_LOW:   cfg_reg.wm_low         <= pwdata[15:0];
                REG_WM_HIGH:  cfg_reg.wm_high        <= pwdata[15:0];
                REG_LIMIT_WM: cfg_reg.limit_wm       <= pwdata[15:0];
                REG_GAIN:     cfg_reg.rate_gain      <= pwdata[15:0];
                REG_WINDOW:   cfg_reg.load_window_ms <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_WM_LOW:   prdata = CFG_DW'(cfg_reg.wm_low);
            REG_WM_HIGH:  prdata = CFG_DW'(cfg_reg.wm_high);
            REG_LIMIT_WM: prdata = CFG_DW'(cfg_reg.limit_wm);
            REG_GAIN:     prdata = CFG_DW'(cfg_reg.rate_gain);
            REG_WINDOW:   prdata = cfg_reg.load_window_ms;
            default:      prdata = '0;
        endcase
    end

    laep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    laep_dp #(
        .BYTE_BITS         (BYTE_BITS),
        .DECAY_TABLE_DEPTH (DECAY_TABLE_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .st         (st),
        .in_mode    (s_tuser),
        .in_commit  (s_tdata[0]),
        .in_bytes   (s_tdata[BB:1]),
        .in_used    (s_tdata[2*BB:BB+1]),
        .in_cap     (s_tdata[3*BB:2*BB+1]),
        .in_minr    (s_tdata[4*BB:3*BB+1]),
        .in_elapsed (s_tdata[4*BB+32:4*BB+1]),
        .in_key     (s_tdata[4*BB+64:4*BB+33]),
        .in_last    (s_tlast),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_kind     (m_tuser),
        .m_key      (m_key),
        .m_bytes    (m_bytes),
        .m_target   (m_target),
        .m_wm       (m_wm),
        .m_sf       (m_sf),
        .m_last     (m_tlast)
    );

    assign m_tdata = OUT_TW'({m_sf, m_wm, m_target, m_bytes, m_key});

endmodule
